// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is high.
`define ASSERT_CLK_RST(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Clocked assertion that is checked in every cycle, reset included.
`define ASSERT_CLK(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// ----- rtl/core/lpni_pkg.sv -----
// Shared constants and controller/datapath signal groups of the perfect number search.
`timescale 1ns / 1ps

package lpni_pkg;

   // Default configuration of the block.
   localparam int MAX_ITEMS_DEFAULT  = 128;
   localparam int VALUE_BITS_DEFAULT = 16;

   // Width of the reported position field.
   localparam int POSITION_BITS = 7;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_item;   // capture the accepted item and set up the first trial
      logic div_start;   // start one remainder computation
      logic accum;       // add the trial divisor if it divides, step to the next one
      logic finish;      // record the test outcome and, on a last item, emit a result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic need_trials; // value is at least two, so trial division has work
      logic div_done;    // remainder unit has finished
      logic last_trial;  // current divisor is the final candidate
      logic item_last;   // captured item closes the array
      logic out_free;    // result register can take a new item
   } status_type;

endpackage

// ----- rtl/core/lpni_if.sv -----
// Valid/ready channel interfaces for the request and response items.
`timescale 1ns / 1ps

interface lpni_req_if #(
   parameter int VALUE_BITS = lpni_pkg::VALUE_BITS_DEFAULT
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;
   logic                         is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface lpni_rsp_if;
   logic                               valid;
   logic                               ready;
   logic                               found;
   logic [lpni_pkg::POSITION_BITS-1:0] position;

   modport source (output valid, output found, output position, input ready);
   modport sink   (input valid, input found, input position, output ready);
endinterface

// ----- rtl/core/lpni_divider.sv -----
// Iterative restoring remainder unit, one quotient bit per cycle.
`timescale 1ns / 1ps

module lpni_divider #(
   parameter int WIDTH = lpni_pkg::VALUE_BITS_DEFAULT - 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic [WIDTH-1:0] remainder,
   output logic             done
);

   localparam int CNT_BITS = $clog2(WIDTH + 1);

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [WIDTH-1:0]    rem_ff, rem_in;
   logic [WIDTH-1:0]    shift_ff, shift_in;
   logic [WIDTH:0]      trial;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   always_comb begin
      trial    = {rem_ff, shift_ff[WIDTH-1]};
      count_in = count_ff;
      rem_in   = rem_ff;
      shift_in = shift_ff;
      if (start) begin
         count_in = CNT_BITS'(WIDTH);
         rem_in   = '0;
         shift_in = dividend;
      end else if (count_ff != '0) begin
         count_in = count_ff - 1'b1;
         shift_in = {shift_ff[WIDTH-2:0], 1'b0};
         if (trial >= {1'b0, divisor}) begin
            rem_in = WIDTH'(trial - {1'b0, divisor});
         end else begin
            rem_in = trial[WIDTH-1:0];
         end
      end
   end

   // The step counter is control state; the working words need no reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      rem_ff   <= rem_in;
      shift_ff <= shift_in;
   end

   assign remainder = rem_ff;
   assign done      = (count_ff == '0);

endmodule

// ----- rtl/core/lpni_datapath.sv -----
// Datapath: trial divisor, divisor sum, array position tracking and result register.
`timescale 1ns / 1ps

module lpni_datapath #(
   parameter int MAX_ITEMS  = lpni_pkg::MAX_ITEMS_DEFAULT,
   parameter int VALUE_BITS = lpni_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lpni_pkg::cmd_type                  cmd,
   output lpni_pkg::status_type               status,
   input  logic signed [VALUE_BITS-1:0]       req_value,
   input  logic                               req_is_last,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic [lpni_pkg::POSITION_BITS-1:0] rsp_position
);

   // A positive value fits in one bit less than the field.
   localparam int UW       = VALUE_BITS - 1;
   // The proper divisor sum stays below five times the value in this range.
   localparam int SW       = VALUE_BITS + 3;
   localparam int CW       = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int PW       = lpni_pkg::POSITION_BITS;
   localparam logic [CW-1:0] COUNT_TOP = CW'(MAX_ITEMS - 1);

   logic [UW-1:0] value_ff;
   logic          positive_ff;
   logic          last_ff;
   logic [UW-1:0] divisor_ff, divisor_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [UW-1:0] remainder;
   logic [UW-1:0] half_value;
   logic          div_done;
   logic          perfect;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] match_pos_ff, match_pos_in;
   logic          match_seen_ff, match_seen_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          found_ff, found_in;
   logic [PW-1:0] position_ff, position_in;

   lpni_divider #(
      .WIDTH (UW)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (value_ff),
      .divisor   (divisor_ff),
      .remainder (remainder),
      .done      (div_done)
   );

   assign half_value = value_ff >> 1;
   assign perfect    = positive_ff && (sum_ff == SW'(value_ff));

   // Trial divisor and running sum of the divisors found so far.
   always_comb begin
      divisor_in = divisor_ff;
      sum_in     = sum_ff;
      if (cmd.load_item) begin
         divisor_in = UW'(1);
         sum_in     = '0;
      end else if (cmd.accum) begin
         divisor_in = divisor_ff + 1'b1;
         if (remainder == '0) begin
            sum_in = sum_ff + SW'(divisor_ff);
         end
      end
   end

   // Array bookkeeping and the result register.
   always_comb begin
      logic          seen_now;
      logic [CW-1:0] pos_now;
      seen_now      = match_seen_ff | perfect;
      pos_now       = perfect ? count_ff : match_pos_ff;
      count_in      = count_ff;
      match_pos_in  = match_pos_ff;
      match_seen_in = match_seen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      found_in      = found_ff;
      position_in   = position_ff;
      if (cmd.finish) begin
         match_seen_in = seen_now;
         match_pos_in  = pos_now;
         if (count_ff < COUNT_TOP) begin
            count_in = count_ff + 1'b1;
         end
         if (last_ff) begin
            rsp_valid_in  = 1'b1;
            found_in      = seen_now;
            position_in   = seen_now ? PW'(pos_now) : '0;
            count_in      = '0;
            match_pos_in  = '0;
            match_seen_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         match_pos_ff  <= '0;
         match_seen_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         match_pos_ff  <= match_pos_in;
         match_seen_ff <= match_seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (cmd.load_item) begin
         value_ff    <= req_value[UW-1:0];
         positive_ff <= !req_value[VALUE_BITS-1] && (req_value != '0);
         last_ff     <= req_is_last;
      end
      divisor_ff  <= divisor_in;
      sum_ff      <= sum_in;
      found_ff    <= found_in;
      position_ff <= position_in;
   end

   // Status toward the controller.
   assign status.need_trials = positive_ff && (half_value != '0);
   assign status.div_done    = div_done;
   assign status.last_trial  = (divisor_ff == half_value);
   assign status.item_last   = last_ff;
   assign status.out_free    = !rsp_valid_ff || rsp_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = found_ff;
   assign rsp_position = position_ff;

endmodule

// ----- rtl/core/lpni_ctrl.sv -----
// Controller state machine that sequences the trial division of each item.
`timescale 1ns / 1ps

module lpni_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output lpni_pkg::cmd_type    cmd,
   input  lpni_pkg::status_type status
);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CHECK = 6'b000010,
      ST_START = 6'b000100,
      ST_DIV   = 6'b001000,
      ST_ACC   = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state and the command issued in each state.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = status.need_trials ? ST_START : ST_DONE;
         end
         ST_START: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (status.div_done) begin
               state_in = ST_ACC;
            end
         end
         ST_ACC: begin
            cmd.accum = 1'b1;
            state_in  = status.last_trial ? ST_DONE : ST_START;
         end
         ST_DONE: begin
            // A last item waits until the result register is free.
            if (!status.item_last || status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// ----- rtl/core/last_perfect_number_index.sv -----
// Top level of the last perfect number index search over a stream of values.
//
//   channel | direction | payload                    | handshake
//   --------+-----------+----------------------------+------------------------
//   req_if  | in        | value (signed), is_last    | valid/ready
//   rsp_if  | out       | found, position            | valid/ready, registered
//
// One item at a time. For a value v of two or more, each candidate divisor up to
// floor(v/2) takes a start state, a pass through the bit-serial remainder unit
// and an accumulate state. Other values go from the check state straight to the
// done state. The worst case at the default width is the value 32767.
// A last item waits only if the previous result has not been taken yet.
// Synchronous reset clears the controller, array position state and response valid.
`timescale 1ns / 1ps

module last_perfect_number_index #(
   parameter int MAX_ITEMS  = lpni_pkg::MAX_ITEMS_DEFAULT,
   parameter int VALUE_BITS = lpni_pkg::VALUE_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   lpni_req_if.sink   req_if,
   lpni_rsp_if.source rsp_if
);

   lpni_pkg::cmd_type    cmd;
   lpni_pkg::status_type status;

   lpni_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .cmd       (cmd),
      .status    (status)
   );

   lpni_datapath #(
      .MAX_ITEMS  (MAX_ITEMS),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_value    (req_if.value),
      .req_is_last  (req_if.is_last),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_found    (rsp_if.found),
      .rsp_position (rsp_if.position)
   );

endmodule

// ----- rtl/core/lpni_checker.sv -----
// Port-level assertions of the perfect number search and their binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpni_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_found,
   input logic [lpni_pkg::POSITION_BITS-1:0] rsp_position
);

   // The whole response payload as one word.
   logic [lpni_pkg::POSITION_BITS:0] rsp_payload;

   assign rsp_payload = {rsp_found, rsp_position};

   // A stalled response item stays offered with the same payload.
   `ASSERT_CLK_RST(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `ASSERT_CLK_RST(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_payload))

   // A miss always reports position zero.
   `ASSERT_CLK_RST(a_miss_zero, clock, reset, rsp_valid && !rsp_found |-> rsp_position == '0)

   // Reset leaves no response item pending.
   `ASSERT_CLK(a_reset_clear, clock, reset |=> !rsp_valid)

   // An accepted item keeps the block busy in the following cycle.
   `ASSERT_CLK_RST(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready)

endmodule

bind last_perfect_number_index lpni_checker u_lpni_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_found    (rsp_if.found),
   .rsp_position (rsp_if.position)
);

// ----- tb/tb_last_perfect_number_index.sv -----
// Self-checking testbench for the last perfect number index search.
`timescale 1ns / 1ps

module tb_last_perfect_number_index;

   localparam int MAX_POS = lpni_pkg::MAX_ITEMS_DEFAULT - 1;

   // Outcome reported at the end of one array.
   typedef struct packed {
      logic                               found;
      logic [lpni_pkg::POSITION_BITS-1:0] position;
   } array_verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpni_req_if req_ch ();
   lpni_rsp_if rsp_ch ();

   last_perfect_number_index dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #6 clock = ~clock;

   // Running state of the search, as the block should hold it.
   int unsigned                        elem_index = 0;
   logic [lpni_pkg::POSITION_BITS-1:0] latest_hit = '0;
   bit                                 hit_seen   = 1'b0;
   array_verdict_type                  pending_verdicts[$];

   int  mismatches = 0;
   bit  idle_on    = 1'b1;
   int  stall_left = 0;
   int  random_sent = 0;

   // Sum of proper divisors by trial division; zero and negatives never qualify.
   function automatic bit perfect_value(input logic signed [15:0] v);
      int n;
      int d;
      int sum;
      if (v <= 0) return 1'b0;
      n   = v;
      sum = 0;
      for (d = 1; d <= n / 2; d++) begin
         if (n % d == 0) sum += d;
      end
      return sum == n;
   endfunction

   // Advance the search by one accepted element and queue a verdict on the last one.
   function automatic void track_element(input logic signed [15:0] v, input bit last);
      array_verdict_type verdict;
      if (perfect_value(v)) begin
         hit_seen   = 1'b1;
         latest_hit = elem_index[lpni_pkg::POSITION_BITS-1:0];
      end
      if (elem_index < MAX_POS) elem_index++;
      if (last) begin
         verdict.found    = hit_seen;
         verdict.position = hit_seen ? latest_hit : '0;
         pending_verdicts.push_back(verdict);
         elem_index = 0;
         latest_hit = '0;
         hit_seen   = 1'b0;
      end
   endfunction

   // Present one item, possibly after an idle burst, and wait until it is taken.
   // Valid stays high on return so that back-to-back items need no extra cycle.
   task automatic send_element(input logic signed [15:0] v, input bit last);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.value   <= v;
      req_ch.is_last <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      track_element(v, last);
   endtask

   // Stop sending and hold off until every queued verdict has been checked.
   task automatic wait_all_verdicts();
      req_ch.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Cheap element that is never perfect, used to fill long arrays.
   function automatic logic signed [15:0] filler_value();
      case ($urandom_range(0, 2))
         0: return 16'sd0;
         1: return 16'sd1;
         default: return 16'($urandom_range(32768, 65535));
      endcase
   endfunction

   // Random element biased toward perfect values and their neighbors.
   function automatic logic signed [15:0] random_value();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
         case ($urandom_range(0, 2))
            0: return 16'sd6;
            1: return 16'sd28;
            default: return 16'sd496;
         endcase
      end else if (sel < 35) begin
         case ($urandom_range(0, 5))
            0: return 16'sd5;
            1: return 16'sd7;
            2: return 16'sd27;
            3: return 16'sd29;
            4: return 16'sd495;
            default: return 16'sd497;
         endcase
      end else if (sel < 65) begin
         return 16'($urandom_range(1, 300));
      end else if (sel < 75) begin
         return 16'($urandom_range(301, 2000));
      end else if (sel < 88) begin
         return 16'($urandom_range(32768, 65535));
      end else if (sel < 94) begin
         return 16'sd0;
      end else begin
         return -16'($urandom_range(1, 3) == 1 ? 6 : 28);
      end
   endfunction

   // Field extremes, each perfect number, negatives and near misses.
   task automatic test_directed_values();
      send_element(16'sd1, 1'b0);
      send_element(16'sd6, 1'b0);
      send_element(16'sd2, 1'b0);
      send_element(16'sd28, 1'b0);
      send_element(16'sd0, 1'b1);
      send_element(-16'sd32768, 1'b0);
      send_element(-16'sd6, 1'b0);
      send_element(-16'sd1, 1'b0);
      send_element(16'sd0, 1'b1);
      send_element(16'sd32767, 1'b1);
      send_element(16'sd8128, 1'b0);
      send_element(16'sd496, 1'b0);
      send_element(16'sd5, 1'b1);
      send_element(16'sd6, 1'b1);
      send_element(16'sd27, 1'b0);
      send_element(16'sd29, 1'b0);
      send_element(16'sd12, 1'b0);
      send_element(16'sd7, 1'b1);
   endtask

   // Arrays longer than the position range: the index must saturate.
   task automatic test_saturated_position();
      int i;
      for (i = 0; i < 135; i++) begin
         if (i == 0) send_element(16'sd6, 1'b0);
         else if (i == 130) send_element(16'sd28, 1'b0);
         else send_element(filler_value(), i == 134);
      end
      for (i = 0; i < 129; i++) begin
         if (i == 126) send_element(16'sd6, 1'b0);
         else send_element(filler_value(), i == 128);
      end
   endtask

   // Well-formed random arrays; the final stretch runs without idling.
   task automatic test_random_arrays();
      int len;
      int i;
      while (random_sent < 100) begin
         idle_on = (random_sent < 40) || (random_sent >= 50 && random_sent < 75);
         len = $urandom_range(1, 6);
         for (i = 0; i < len; i++) begin
            send_element(random_value(), i == len - 1);
            random_sent++;
         end
      end
   endtask

   // Receiver readiness with random stall bursts.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(1, 17) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Compare each accepted result with the oldest queued verdict.
   always @(posedge clock) begin
      array_verdict_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: found=%0d position=%0d",
                        rsp_ch.found, rsp_ch.position);
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_ch.found !== want.found || rsp_ch.position !== want.position) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected found=%0d position=%0d, got found=%0d position=%0d",
                           want.found, want.position, rsp_ch.found, rsp_ch.position);
            end
         end
      end
   end

   // Test sequence.
   initial begin
      req_ch.valid   = 1'b0;
      req_ch.value   = '0;
      req_ch.is_last = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_directed_values();
      wait_all_verdicts();
      test_saturated_position();
      test_random_arrays();
      wait_all_verdicts();
      repeat (20) @(posedge clock);

      if (pending_verdicts.size() != 0) begin
         mismatches++;
         $display("%0d expected results never arrived", pending_verdicts.size());
      end
      if (mismatches == 0) begin
         $display("tb_last_perfect_number_index: PASS");
      end else begin
         $display("tb_last_perfect_number_index: FAIL");
      end
      $finish;
   end

   // Guard against a hung handshake.
   initial begin
      #(120_000_000);
      $display("tb_last_perfect_number_index: FAIL");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/lpni_pkg.sv
rtl/core/lpni_if.sv
rtl/core/lpni_divider.sv
rtl/core/lpni_datapath.sv
rtl/core/lpni_ctrl.sv
rtl/core/last_perfect_number_index.sv
rtl/core/lpni_checker.sv
tb/tb_last_perfect_number_index.sv
